// ===== hdl/etpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo and three-point average package
// Shared widths, register indexes and reset values of the echo averager.
// ----------------------------------------------------------------------------
package etpa_pkg;

   localparam int GAIN_BITS      = 15;
   localparam int DELAY_BITS     = 15;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ECHO_DELAY = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ECHO_GAIN  = CSR_INDEX_BITS'(1);

   localparam logic [DELAY_BITS-1:0] ECHO_DELAY_RESET = DELAY_BITS'(13230);
   localparam logic [GAIN_BITS-1:0]  ECHO_GAIN_RESET  = GAIN_BITS'(13107);

endpackage

// ===== hdl/etpa_req_if.sv =====
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one audio sample and its first flag.
// ----------------------------------------------------------------------------
interface etpa_req_if #(
   parameter int SAMPLE_BITS = 16
) ();

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);

endinterface

// ===== hdl/etpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Filtered response channel
// Valid/ready channel that carries one echoed and averaged sample.
// ----------------------------------------------------------------------------
interface etpa_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();

   logic                            valid;
   logic                            ready;
   logic signed [SAMPLE_BITS+1:0]   filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);

endinterface

// ===== hdl/etpa_csr_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface etpa_csr_if
   import etpa_pkg::*;
();

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== hdl/etpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
module etpa_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 16384,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/echo_then_three_point_average_core.sv =====
// ----------------------------------------------------------------------------
// Echo then three-point average core
// Adds a feed-forward echo to each audio sample and averages the echoed
// signal over three samples.
//
// Samples enter on the request channel; each carries a first flag that
// restarts the signal history. Every transfer in produces exactly one
// transfer out on the response channel, in order. The configuration
// channel sets the echo delay and gain and is always ready; it is meant
// to be written while no sample is in flight.
//
// Throughput is one sample per clock. A request transfer registers the
// delay-line read and the sample into stage one; the gain multiply and echo
// add go into stage two, the three-point sum into stage three and the
// divide-by-three multiply into the output register. When the receiver
// stalls the whole pipeline holds and the request channel drops ready until
// the output register drains. Reset clears the history and the pointers
// and restores the default delay and gain; the delay-line memory itself is
// not cleared.
// ----------------------------------------------------------------------------
module echo_then_three_point_average_core
   import etpa_pkg::*;
#(
   parameter int MAX_DELAY   = 16384,
   parameter int SAMPLE_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   etpa_req_if.sink   req_port,
   etpa_rsp_if.source rsp_port,
   etpa_csr_if.sink   csr_port
);

   localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int CW   = $clog2(MAX_DELAY + 1);
   localparam int RW   = AW + 2;
   localparam int EW   = SAMPLE_BITS + 2;
   localparam int SW   = SAMPLE_BITS + 3;
   localparam int PW   = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int KDIV = SW + 2;
   localparam longint unsigned RECIP3_FULL = ((64'd1 << KDIV) + 64'd2) / 64'd3;
   localparam logic [KDIV-1:0] RECIP3      = RECIP3_FULL[KDIV-1:0];
   localparam logic [SW-1:0]   DIV_BIAS    = SW'(3) << SAMPLE_BITS;
   localparam logic [SW-1:0]   DIV_OFFSET  = SW'(1) << SAMPLE_BITS;

   // Configuration registers.
   logic [DELAY_BITS-1:0] echo_delay_ff;
   logic [GAIN_BITS-1:0]  echo_gain_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_delay_ff <= ECHO_DELAY_RESET;
         echo_gain_ff  <= ECHO_GAIN_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_ECHO_DELAY: echo_delay_ff <= csr_port.data[DELAY_BITS-1:0];
            REG_ECHO_GAIN:  echo_gain_ff  <= csr_port.data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control.
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;
   assign accept         = req_port.valid && advance;

   // Input stage: delay-line addressing and fill tracking.
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] fill_ff, fill_in, fill_used;
   logic [CW-1:0] delay_sat;
   logic [RW-1:0] rd_sum, rd_mod;
   logic [AW-1:0] rd_addr;
   logic          active;

   always_comb begin
      if (32'(echo_delay_ff) > MAX_DELAY) begin
         delay_sat = CW'(MAX_DELAY);
      end else begin
         delay_sat = CW'(echo_delay_ff);
      end
      fill_used = req_port.first ? '0 : fill_ff;
      active    = fill_used >= delay_sat;
      if (fill_used < CW'(MAX_DELAY)) begin
         fill_in = fill_used + CW'(1);
      end else begin
         fill_in = fill_used;
      end
      if (wr_ptr_ff == AW'(MAX_DELAY - 1)) begin
         wr_ptr_in = '0;
      end else begin
         wr_ptr_in = wr_ptr_ff + AW'(1);
      end
      rd_sum = RW'(wr_ptr_ff) + RW'(MAX_DELAY) - RW'(delay_sat);
      if (rd_sum >= RW'(MAX_DELAY)) begin
         rd_mod = rd_sum - RW'(MAX_DELAY);
      end else begin
         rd_mod = rd_sum;
      end
      rd_addr = rd_mod[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (accept) begin
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   logic [SAMPLE_BITS-1:0] ram_rd_data;

   etpa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_DELAY)
   ) delay_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_port.sample),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stage one: sample, flags and delayed sample from the RAM.
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_first_ff;
   logic                          s1_active_ff;
   logic                          s1_self_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= req_port.sample;
         s1_first_ff  <= req_port.first;
         s1_active_ff <= active;
         s1_self_ff   <= (delay_sat == '0);
      end
   end

   logic signed [SAMPLE_BITS-1:0] delayed;
   logic signed [GAIN_BITS:0]     gain_s;
   logic signed [PW-1:0]          product;
   logic signed [PW-1:0]          product_rnd;
   logic signed [SAMPLE_BITS:0]   echo_term;
   logic signed [EW-1:0]          echo_in;

   always_comb begin
      delayed     = s1_self_ff ? s1_sample_ff : $signed(ram_rd_data);
      gain_s      = $signed({1'b0, echo_gain_ff});
      product     = PW'(gain_s) * PW'(delayed);
      product_rnd = (product + (PW'(1) <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
      echo_term   = s1_active_ff ? product_rnd[SAMPLE_BITS:0] : '0;
      echo_in     = EW'(s1_sample_ff) + EW'(echo_term);
   end

   // Stage two: echoed sample and the averaging history.
   logic                 s2_valid_ff;
   logic                 s2_first_ff;
   logic signed [EW-1:0] s2_echo_ff;
   logic signed [EW-1:0] echo_prev1_ff, echo_prev2_ff;
   logic signed [EW-1:0] hist1, hist2;
   logic signed [SW-1:0] sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_echo_ff  <= echo_in;
         s2_first_ff <= s1_first_ff;
      end
   end

   always_comb begin
      hist1  = s2_first_ff ? '0 : echo_prev1_ff;
      hist2  = s2_first_ff ? '0 : echo_prev2_ff;
      sum_in = SW'(s2_echo_ff) + SW'(hist1) + SW'(hist2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_prev1_ff <= '0;
         echo_prev2_ff <= '0;
      end else if (advance && s2_valid_ff) begin
         echo_prev1_ff <= s2_echo_ff;
         echo_prev2_ff <= hist1;
      end
   end

   // Stage three: rounded divide by three through a reciprocal multiply.
   logic                 s3_valid_ff;
   logic signed [SW-1:0] s3_sum_ff;
   logic [SW-1:0]        div_num;
   logic [SW+KDIV-1:0]   div_prod;
   logic [SW-1:0]        div_quot;
   logic [SW-1:0]        avg_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sum_ff <= sum_in;
      end
   end

   always_comb begin
      div_num  = $unsigned(s3_sum_ff) + SW'(1) + DIV_BIAS;
      div_prod = (SW+KDIV)'(div_num) * (SW+KDIV)'(RECIP3);
      div_quot = div_prod[SW+KDIV-1:KDIV];
      avg_full = div_quot - DIV_OFFSET;
   end

   // Output register.
   logic signed [EW-1:0] filtered_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         filtered_ff <= $signed(avg_full[EW-1:0]);
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.filtered = filtered_ff;

   // Assertions.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_DELAY))
      else $error("fill count exceeds the delay-line depth");

   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      32'(wr_ptr_ff) < MAX_DELAY)
      else $error("write pointer outside the delay line");

   a_first_restart : assert property (@(posedge clock) disable iff (reset)
      (accept && req_port.first) |=> (fill_ff == CW'(1)))
      else $error("first flag did not restart the fill count");

   a_first_history : assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_first_ff) |=> (echo_prev2_ff == '0))
      else $error("first flag did not clear the averaging history");

endmodule
